@@ sv/lakv_pkg.sv @@
// Package for the lookahead array key-value store.
// Holds default sizes, status and function codes and the channel word types.
// No dependencies.
`timescale 1ns / 1ps

package lakv_pkg;

  localparam int LEVELS_DEF     = 10;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_GET    = 2'd2;
  localparam logic [1:0] FN_GET3   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [9:0]  entry_count;
  } rsp_t;

endpackage

@@ sv/lakv_if.sv @@
// Valid/ready channel interfaces for request and response words.
// Depends on lakv_pkg for the word types.
`timescale 1ns / 1ps

interface lakv_req_if;
  logic            valid;
  logic            ready;
  lakv_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lakv_rsp_if;
  logic            valid;
  logic            ready;
  lakv_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/lakv_mem.sv @@
// Entry memory: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lakv_mem #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 65,
  parameter int DEPTH  = 1023
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/lookahead_array_key_value_store.sv @@
// Top level of the lookahead array key-value store; uses lakv_pkg, lakv_if, lakv_mem.
// Holds the sequencer that drives the key compares and the entry memory.
`timescale 1ns / 1ps

// Sorted levels of 1, 2, 4 ... entries in one memory of 2^LEVELS-1 words; bit i of the
// entry count marks level i full. One request is handled at a time and a response word
// follows every request. Each search or merge step is one read of the single memory port
// followed by one key compare, so timing is set by that port: a get makes at most lv+1
// binary-search probes in each full level lv; an insert or remove merges the levels below
// the first empty one word by word, then moves words back down when duplicates were dropped.
// A full store answers an insert or remove at once.
// No clearing pass is needed after reset.
module lookahead_array_key_value_store #(
  parameter int LEVELS     = lakv_pkg::LEVELS_DEF,
  parameter int KEY_BITS   = lakv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lakv_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lakv_req_if.sink    req,
  lakv_rsp_if.source  rsp
);

  localparam int ADDR_W = LEVELS;
  localparam int E_W    = 1 + KEY_BITS + VALUE_BITS;
  localparam int LV_W   = $clog2(LEVELS + 1);
  localparam int LI_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [LEVELS-1:0] CAP = {LEVELS{1'b1}};

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_M_BEGIN  = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CMP = 4'd3;
  localparam logic [3:0] S_DECIDE   = 4'd4;
  localparam logic [3:0] S_TAKE_RD  = 4'd5;
  localparam logic [3:0] S_TAKE_CMP = 4'd6;
  localparam logic [3:0] S_R_LEVEL  = 4'd7;
  localparam logic [3:0] S_R_RD     = 4'd8;
  localparam logic [3:0] S_R_WR     = 4'd9;
  localparam logic [3:0] S_L_LEVEL  = 4'd10;
  localparam logic [3:0] S_L_RD     = 4'd11;
  localparam logic [3:0] S_L_CMP    = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  function automatic logic [LEVELS-1:0] lvl_size(input logic [LV_W-1:0] l);
    return LEVELS'(1) << l;
  endfunction

  logic [3:0]            state;
  logic [LEVELS-1:0]     count;
  logic [LEVELS-1:0]     heads [LEVELS];
  logic [E_W-1:0]        new_ent;
  logic [KEY_BITS-1:0]   qkey;
  logic [KEY_BITS-1:0]   best;
  logic                  any;
  logic                  pend;
  logic                  taken;
  logic [LV_W-1:0]       id;
  logic [LV_W-1:0]       lv;
  logic [ADDR_W-1:0]     wr;
  logic [ADDR_W-1:0]     base;
  logic [LEVELS-1:0]     disc;
  logic [LEVELS-1:0]     moves;
  logic [ADDR_W-1:0]     src;
  logic [ADDR_W-1:0]     dst;
  logic [LEVELS-1:0]     jcnt;
  logic [LEVELS-1:0]     lo;
  logic [LEVELS-1:0]     hi;
  logic [1:0]            status;
  logic [VALUE_BITS-1:0] rv;
  logic                  out_valid;
  lakv_pkg::rsp_t        out_word;

  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [E_W-1:0]        mem_wdata;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [E_W-1:0]        rdata;

  logic [LI_W-1:0]       li;
  logic                  head_ok;
  logic [ADDR_W-1:0]     head_slot;
  logic [LV_W-1:0]       id_c;
  logic [LEVELS:0]       sum_lh;
  logic [ADDR_W-1:0]     mid;
  logic [KEY_BITS-1:0]   rkey;
  logic [KEY_BITS-1:0]   in_key;

  assign li        = lv[LI_W-1:0];
  assign head_ok   = heads[li] < lvl_size(lv);
  assign head_slot = ADDR_W'(lvl_size(lv) - LEVELS'(1) + heads[li]);
  assign sum_lh    = (LEVELS + 1)'(lo) + (LEVELS + 1)'(hi);
  assign mid       = sum_lh[LEVELS:1];
  assign rkey      = rdata[VALUE_BITS +: KEY_BITS];
  assign in_key    = KEY_BITS'(req.data.key);

  // first empty level
  always_comb begin
    id_c = LV_W'(LEVELS);
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (!count[i]) id_c = LV_W'(i);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr;
    mem_wdata = rdata;
    mem_raddr = head_slot;
    case (state)
      S_DECIDE: begin
        mem_wdata = new_ent;
        mem_we    = any && pend && (new_ent[VALUE_BITS +: KEY_BITS] == best);
      end
      S_TAKE_CMP: mem_we = (rkey == best) && !taken;
      S_R_RD:     mem_raddr = src;
      S_R_WR: begin
        mem_we    = 1'b1;
        mem_waddr = dst;
      end
      S_L_RD:     mem_raddr = mid;
      default: ;
    endcase
  end

  lakv_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (E_W),
    .DEPTH  (int'(CAP))
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < LEVELS; i++) heads[i] <= '0;
    end else begin
      if (out_valid && rsp.ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            qkey   <= in_key;
            rv     <= '0;
            lv     <= '0;
            if (req.data.func[1]) begin
              status <= lakv_pkg::ST_OK;
              state  <= S_L_LEVEL;
            end else if (count == CAP) begin
              status <= lakv_pkg::ST_FULL;
              state  <= S_DONE;
            end else begin
              status <= lakv_pkg::ST_OK;
              if (req.data.func == lakv_pkg::FN_INSERT) begin
                new_ent <= {1'b1, in_key, VALUE_BITS'(req.data.value)};
              end else begin
                new_ent <= {1'b0, in_key, {VALUE_BITS{1'b0}}};
              end
              id   <= id_c;
              base <= ADDR_W'(lvl_size(id_c) - LEVELS'(1));
              wr   <= ADDR_W'(lvl_size(id_c) - LEVELS'(1));
              pend <= 1'b1;
              disc <= '0;
              for (int i = 0; i < LEVELS; i++) heads[i] <= '0;
              state <= S_M_BEGIN;
            end
          end
        end
        S_M_BEGIN: begin
          best  <= qkey;
          any   <= pend;
          taken <= 1'b0;
          lv    <= '0;
          state <= S_SCAN_RD;
        end
        S_SCAN_RD: begin
          if (lv == id) begin
            state <= S_DECIDE;
          end else if (head_ok) begin
            state <= S_SCAN_CMP;
          end else begin
            lv <= lv + LV_W'(1);
          end
        end
        S_SCAN_CMP: begin
          if (!any || rkey < best) begin
            best <= rkey;
            any  <= 1'b1;
          end
          lv    <= lv + LV_W'(1);
          state <= S_SCAN_RD;
        end
        S_DECIDE: begin
          if (!any) begin
            count <= count + LEVELS'(1) - disc;
            if (disc != '0) begin
              moves <= lvl_size(id) - disc;
              src   <= base;
              lv    <= '0;
              state <= S_R_LEVEL;
            end else begin
              state <= S_DONE;
            end
          end else begin
            if (mem_we) begin
              wr    <= wr + ADDR_W'(1);
              taken <= 1'b1;
              pend  <= 1'b0;
            end
            lv    <= '0;
            state <= S_TAKE_RD;
          end
        end
        S_TAKE_RD: begin
          if (lv == id) begin
            state <= S_M_BEGIN;
          end else if (head_ok) begin
            state <= S_TAKE_CMP;
          end else begin
            lv <= lv + LV_W'(1);
          end
        end
        S_TAKE_CMP: begin
          if (rkey == best) begin
            // newest copy goes through, older copies are dropped
            if (!taken) begin
              wr    <= wr + ADDR_W'(1);
              taken <= 1'b1;
            end else begin
              disc <= disc + LEVELS'(1);
            end
            heads[li] <= heads[li] + LEVELS'(1);
          end
          lv    <= lv + LV_W'(1);
          state <= S_TAKE_RD;
        end
        S_R_LEVEL: begin
          if (lv == id) begin
            state <= S_DONE;
          end else if (moves[li]) begin
            dst   <= ADDR_W'(lvl_size(lv) - LEVELS'(1));
            jcnt  <= '0;
            state <= S_R_RD;
          end else begin
            lv <= lv + LV_W'(1);
          end
        end
        S_R_RD: begin
          src   <= src + ADDR_W'(1);
          state <= S_R_WR;
        end
        S_R_WR: begin
          dst  <= dst + ADDR_W'(1);
          jcnt <= jcnt + LEVELS'(1);
          if (jcnt == lvl_size(lv) - LEVELS'(1)) begin
            lv    <= lv + LV_W'(1);
            state <= S_R_LEVEL;
          end else begin
            state <= S_R_RD;
          end
        end
        S_L_LEVEL: begin
          if (lv == LV_W'(LEVELS)) begin
            status <= lakv_pkg::ST_NOTFOUND;
            state  <= S_DONE;
          end else if (count[li]) begin
            lo    <= lvl_size(lv) - LEVELS'(1);
            hi    <= (lvl_size(lv) << 1) - LEVELS'(1);
            state <= S_L_RD;
          end else begin
            lv <= lv + LV_W'(1);
          end
        end
        S_L_RD: begin
          if (lo < hi) begin
            state <= S_L_CMP;
          end else begin
            lv    <= lv + LV_W'(1);
            state <= S_L_LEVEL;
          end
        end
        S_L_CMP: begin
          if (qkey < rkey) begin
            hi    <= mid;
            state <= S_L_RD;
          end else if (rkey < qkey) begin
            lo    <= mid + ADDR_W'(1);
            state <= S_L_RD;
          end else begin
            if (rdata[E_W-1]) begin
              rv <= rdata[VALUE_BITS-1:0];
            end else begin
              status <= lakv_pkg::ST_NOTFOUND;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || rsp.ready) begin
            out_word.status      <= status;
            out_word.read_value  <= 32'(rv);
            out_word.entry_count <= 10'(count);
            out_valid            <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_we_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_DECIDE || state == S_TAKE_CMP || state == S_R_WR))
    else $error("memory write outside merge or spread");

  a_merge_in_level: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state == S_DECIDE || state == S_TAKE_CMP))
      |-> (LEVELS'(wr - base) < lvl_size(id)))
    else $error("merge write beyond target level");

  a_spread_down: assert property (@(posedge clk) disable iff (rst)
    (state == S_R_WR) |-> (dst < src))
    else $error("spread destination not below source");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.status == lakv_pkg::ST_OK ||
                   out_word.status == lakv_pkg::ST_NOTFOUND ||
                   out_word.status == lakv_pkg::ST_FULL))
    else $error("bad status code");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the lookahead array key-value store.
// Depends on lakv_pkg, lakv_if and the block; holds its own store predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int NLEV      = lakv_pkg::LEVELS_DEF;
  localparam int CAPACITY  = (1 << NLEV) - 1;
  localparam int WD_LIMIT  = 400000;
  localparam int N_RANDOM  = 560;

  typedef struct {
    lakv_pkg::req_t rq;
    bit             typed;
    lakv_pkg::rsp_t ex;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lakv_req_if req ();
  lakv_rsp_if rsp ();

  lookahead_array_key_value_store DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #5 clk = ~clk;

  // store predictor state
  logic [32:0] key_mem [CAPACITY];
  logic [31:0] val_mem [CAPACITY];
  int unsigned entry_cnt;
  int unsigned heads [NLEV];

  lakv_pkg::rsp_t expected_rsps [$];
  stim_row_t      dir_rows [$];
  bit   quiet = 1'b0;
  int   errors = 0;
  int   n_sent = 0, n_hits = 0, n_full = 0, n_dropped_merges = 0;
  int   stall_left = 0;
  int   idle_cycles = 0;

  function automatic void merge_entry(logic [32:0] entry, logic [31:0] val);
    int unsigned id, lv, wr, base, disc, moves, src, dst, j, s;
    logic [31:0] newkey, best, k;
    bit pend, any, taken;
    id = 0;
    disc = 0;
    pend = 1'b1;
    newkey = entry[31:0];
    while (id < NLEV && entry_cnt[id]) id++;
    base = (1 << id) - 1;
    wr = base;
    for (lv = 0; lv < id; lv++) heads[lv] = 0;
    forever begin
      any = 1'b0;
      taken = 1'b0;
      best = '0;
      if (pend) begin
        best = newkey;
        any = 1'b1;
      end
      for (lv = 0; lv < id; lv++) begin
        if (heads[lv] < (1 << lv)) begin
          k = key_mem[(1 << lv) - 1 + heads[lv]][31:0];
          if (!any || k < best) begin
            best = k;
            any = 1'b1;
          end
        end
      end
      if (!any) break;
      if (pend && newkey == best) begin
        key_mem[wr] = entry;
        val_mem[wr] = val;
        wr++;
        taken = 1'b1;
        pend = 1'b0;
      end
      // newest copy of a key wins; drop the older ones
      for (lv = 0; lv < id; lv++) begin
        if (heads[lv] < (1 << lv)) begin
          s = (1 << lv) - 1 + heads[lv];
          if (key_mem[s][31:0] == best) begin
            if (!taken) begin
              key_mem[wr] = key_mem[s];
              val_mem[wr] = val_mem[s];
              wr++;
              taken = 1'b1;
            end else begin
              disc++;
            end
            heads[lv]++;
          end
        end
      end
    end
    if (disc != 0) begin
      n_dropped_merges++;
      moves = (1 << id) - disc;
      src = base;
      for (lv = 0; lv < id; lv++) begin
        if (moves[lv]) begin
          dst = (1 << lv) - 1;
          for (j = 0; j < (1 << lv); j++) begin
            key_mem[dst + j] = key_mem[src];
            val_mem[dst + j] = val_mem[src];
            src++;
          end
        end
      end
    end
    entry_cnt = (entry_cnt + 1 - disc) & CAPACITY;
  endfunction

  function automatic logic [1:0] find_key(logic [31:0] key, output logic [31:0] val);
    int unsigned lv, lo, hi, mid;
    logic [32:0] e;
    val = '0;
    for (lv = 0; lv < NLEV; lv++) begin
      if (entry_cnt[lv]) begin
        lo = (1 << lv) - 1;
        hi = (1 << (lv + 1)) - 1;
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          e = key_mem[mid];
          if (key < e[31:0]) begin
            hi = mid;
          end else if (e[31:0] < key) begin
            lo = mid + 1;
          end else if (e[32]) begin
            val = val_mem[mid];
            return lakv_pkg::ST_OK;
          end else begin
            return lakv_pkg::ST_NOTFOUND;
          end
        end
      end
    end
    return lakv_pkg::ST_NOTFOUND;
  endfunction

  function automatic lakv_pkg::rsp_t predict_store(lakv_pkg::req_t r);
    lakv_pkg::rsp_t o;
    logic [31:0] v;
    o.read_value = '0;
    if (r.func[1]) begin
      o.status = find_key(r.key, v);
      o.read_value = v;
      if (o.status == lakv_pkg::ST_OK) n_hits++;
    end else if (entry_cnt >= CAPACITY) begin
      o.status = lakv_pkg::ST_FULL;
      n_full++;
    end else begin
      if (r.func == lakv_pkg::FN_INSERT) merge_entry({1'b1, r.key}, r.value);
      else merge_entry({1'b0, r.key}, 32'd0);
      o.status = lakv_pkg::ST_OK;
    end
    o.entry_count = entry_cnt[9:0];
    return o;
  endfunction

  function automatic stim_row_t row(logic [1:0] f, logic [31:0] k, logic [31:0] v,
                                    bit typed, logic [1:0] st, logic [31:0] rv,
                                    logic [9:0] cnt);
    stim_row_t t;
    t.rq.func = f;
    t.rq.key = k;
    t.rq.value = v;
    t.typed = typed;
    t.ex.status = st;
    t.ex.read_value = rv;
    t.ex.entry_count = cnt;
    return t;
  endfunction

  function automatic void add_row(logic [1:0] f, logic [31:0] k, logic [31:0] v,
                                  bit typed, logic [1:0] st, logic [31:0] rv,
                                  logic [9:0] cnt);
    dir_rows.insert(dir_rows.size(), row(f, k, v, typed, st, rv, cnt));
  endfunction

  // present one word, with an optional idle burst first
  task automatic send_word(lakv_pkg::req_t r, bit typed, lakv_pkg::rsp_t ex);
    lakv_pkg::rsp_t p;
    int n;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 6);
      req.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.data <= r;
    forever begin
      @(posedge clk);
      if (req.ready) break;
    end
    p = predict_store(r);
    expected_rsps.insert(expected_rsps.size(), typed ? ex : p);
    n_sent++;
  endtask

  task automatic send_op(logic [1:0] f, logic [31:0] k, logic [31:0] v);
    lakv_pkg::req_t r;
    lakv_pkg::rsp_t none;
    r.func = f;
    r.key = k;
    r.value = v;
    none = '0;
    send_word(r, 1'b0, none);
  endtask

  task automatic drain();
    @(negedge clk);
    req.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
  endtask

  // response sink with random stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 5);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    lakv_pkg::rsp_t ex;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_rsps.size() == 0) begin
        $error("response word with nothing expected: %p", rsp.data);
        errors++;
      end else begin
        ex = expected_rsps.pop_front();
        if (rsp.data.status !== ex.status) begin
          $error("status: expected %0d, got %0d", ex.status, rsp.data.status);
          errors++;
        end
        if (rsp.data.read_value !== ex.read_value) begin
          $error("read_value: expected %h, got %h", ex.read_value, rsp.data.read_value);
          errors++;
        end
        if (rsp.data.entry_count !== ex.entry_count) begin
          $error("entry_count: expected %0d, got %0d", ex.entry_count,
                 rsp.data.entry_count);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", WD_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [1:0] f;
    logic [31:0] k;
    int i, r;
    req.valid = 1'b0;
    req.data = '0;
    entry_cnt = 0;
    for (i = 0; i < NLEV; i++) heads[i] = 0;
    for (i = 0; i < CAPACITY; i++) begin
      key_mem[i] = '0;
      val_mem[i] = '0;
    end

    add_row(lakv_pkg::FN_GET, 32'd5, 32'd0, 1, lakv_pkg::ST_NOTFOUND, 32'd0, 10'd0);
    add_row(lakv_pkg::FN_INSERT, 32'd0, 32'd0, 1, lakv_pkg::ST_OK, 32'd0, 10'd1);
    add_row(lakv_pkg::FN_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, lakv_pkg::ST_OK,
            32'd0, 10'd2);
    add_row(lakv_pkg::FN_GET, 32'hFFFF_FFFF, 32'd0, 1, lakv_pkg::ST_OK,
            32'hFFFF_FFFF, 10'd2);
    add_row(lakv_pkg::FN_GET, 32'd0, 32'hFFFF_FFFF, 1, lakv_pkg::ST_OK, 32'd0, 10'd2);
    add_row(lakv_pkg::FN_GET3, 32'hFFFF_FFFF, 32'd0, 1, lakv_pkg::ST_OK,
            32'hFFFF_FFFF, 10'd2);
    add_row(lakv_pkg::FN_GET3, 32'd9, 32'd0, 1, lakv_pkg::ST_NOTFOUND, 32'd0, 10'd2);
    add_row(lakv_pkg::FN_INSERT, 32'd0, 32'h1234_5678, 0, lakv_pkg::ST_OK, 32'd0, 10'd0);
    add_row(lakv_pkg::FN_GET, 32'd0, 32'd0, 0, lakv_pkg::ST_OK, 32'd0, 10'd0);
    add_row(lakv_pkg::FN_REMOVE, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 0, lakv_pkg::ST_OK,
            32'd0, 10'd0);
    add_row(lakv_pkg::FN_GET, 32'hFFFF_FFFF, 32'd0, 0, lakv_pkg::ST_OK, 32'd0, 10'd0);
    add_row(lakv_pkg::FN_REMOVE, 32'd77, 32'd0, 0, lakv_pkg::ST_OK, 32'd0, 10'd0);
    add_row(lakv_pkg::FN_GET, 32'd77, 32'd0, 0, lakv_pkg::ST_OK, 32'd0, 10'd0);
    add_row(lakv_pkg::FN_INSERT, 32'h8000_0000, 32'hAAAA_AAAA, 0, lakv_pkg::ST_OK,
            32'd0, 10'd0);
    add_row(lakv_pkg::FN_INSERT, 32'h7FFF_FFFF, 32'h5555_5555, 0, lakv_pkg::ST_OK,
            32'd0, 10'd0);
    add_row(lakv_pkg::FN_INSERT, 32'd77, 32'h0000_0001, 0, lakv_pkg::ST_OK, 32'd0, 10'd0);
    add_row(lakv_pkg::FN_GET, 32'h8000_0000, 32'd0, 0, lakv_pkg::ST_OK, 32'd0, 10'd0);
    add_row(lakv_pkg::FN_GET, 32'h7FFF_FFFF, 32'd0, 0, lakv_pkg::ST_OK, 32'd0, 10'd0);
    add_row(lakv_pkg::FN_GET3, 32'd77, 32'd0, 0, lakv_pkg::ST_OK, 32'd0, 10'd0);
    add_row(lakv_pkg::FN_REMOVE, 32'd0, 32'd0, 0, lakv_pkg::ST_OK, 32'd0, 10'd0);
    add_row(lakv_pkg::FN_GET, 32'd0, 32'd0, 0, lakv_pkg::ST_OK, 32'd0, 10'd0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (i = 0; i < dir_rows.size(); i++) begin
      send_word(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].ex);
    end
    // hold the sender until the store has answered everything
    drain();

    // random mix; a small key pool forces duplicates and tombstone hits
    for (i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(0, 9);
      f = (r < 4) ? lakv_pkg::FN_INSERT : (r < 6) ? lakv_pkg::FN_REMOVE :
          (r < 9) ? lakv_pkg::FN_GET : lakv_pkg::FN_GET3;
      k = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 40));
      send_op(f, k, $urandom());
    end

    // fill to capacity with fresh keys
    while (entry_cnt < CAPACITY) begin
      k = 32'hF000_0000 | 32'(n_sent);
      send_op(lakv_pkg::FN_INSERT, k, $urandom());
      if ($urandom_range(0, 15) == 0) begin
        send_op(lakv_pkg::FN_GET, k ^ 32'($urandom_range(0, 1)), 0);
      end
    end

    drain();
    quiet = 1'b1;
    for (i = 0; i < 30; i++) begin
      f = 2'($urandom_range(0, 3));
      k = ($urandom_range(0, 1) == 0) ? $urandom() : 32'($urandom_range(0, 40));
      send_op(f, k, $urandom());
    end
    drain();
    repeat (200) @(posedge clk);

    $display("Covered %0d requests: %0d get hits, %0d full rejections,", n_sent, n_hits,
             n_full);
    $display("%0d merges that dropped older duplicates; store filled to %0d entries.",
             n_dropped_merges, CAPACITY);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/lakv_pkg.sv
sv/lakv_if.sv
sv/lakv_mem.sv
sv/lookahead_array_key_value_store.sv
tb/sv/tb_top.sv
